@@ rtl/ocep_pkg.sv @@
// Shared types and constants for the capture event parser.
// Holds the sequencer states, datapath command/status structs and decode codes.
// No dependencies.
package ocep_pkg;

   localparam int SIG_LEN       = 8;
   localparam int DATA_START    = 10;
   localparam int PERIOD_OFFSET = 8;

   localparam logic [1:0] KIND_LOAD  = 2'd0;
   localparam logic [1:0] KIND_START = 2'd1;
   localparam logic [1:0] KIND_NEXT  = 2'd2;

   localparam logic [16:0] FULL_PERIOD = 17'h10000;

   localparam logic [7:0] MARK_BYTE  = 8'hFF;
   localparam logic [7:0] CMD_DELAY  = 8'h00;
   localparam logic [7:0] CMD_CTRL   = 8'h02;
   localparam logic [7:0] CTRL_TIMER = 8'h00;
   localparam logic [7:0] CTRL_BASE0 = 8'h01;
   localparam logic [7:0] CTRL_BASE1 = 8'h02;

   localparam logic [9:0] EV_WRITE   = 10'h001;
   localparam logic [9:0] EV_DELAY   = 10'h002;
   localparam logic [9:0] EV_TIMER   = 10'h004;
   localparam logic [9:0] EV_BASE0   = 10'h008;
   localparam logic [9:0] EV_BASE1   = 10'h010;
   localparam logic [9:0] EV_BCHG    = 10'h020;
   localparam logic [9:0] EV_RESTART = 10'h040;
   localparam logic [9:0] EV_STOP    = 10'h080;
   localparam logic [9:0] EV_ENDMARK = 10'h100;
   localparam logic [9:0] EV_UNKNOWN = 10'h200;

   // file signature "RAWADATA"
   function automatic logic [7:0] sig_byte(input logic [2:0] idx);
      logic [7:0] b;
      case (idx)
         3'd0:    b = 8'h52;
         3'd1:    b = 8'h41;
         3'd2:    b = 8'h57;
         3'd3:    b = 8'h41;
         3'd4:    b = 8'h44;
         3'd5:    b = 8'h41;
         3'd6:    b = 8'h54;
         3'd7:    b = 8'h41;
         default: b = 8'h00;
      endcase
      return b;
   endfunction

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DISPATCH,
      ST_SIG_ADDR,
      ST_SIG_CHK,
      ST_HDR_LO,
      ST_HDR_HI,
      ST_HDR_WT,
      ST_EV_RD0,
      ST_EV_RD1,
      ST_EV_WT,
      ST_EV_DEC,
      ST_TM_HI,
      ST_COMMIT
   } state_type;

   typedef enum logic [2:0] {
      ACT_NONE,
      ACT_LOAD,
      ACT_START_OK,
      ACT_START_BAD,
      ACT_REWIND,
      ACT_EVENT,
      ACT_TIMER
   } act_type;

   typedef enum logic [2:0] {
      RS_SIG,
      RS_HDR0,
      RS_HDR1,
      RS_POS0,
      RS_POS1,
      RS_POS2,
      RS_POS3
   } rsel_type;

   typedef struct packed {
      logic       capture;
      logic       set_end;
      rsel_type   rsel;
      logic [2:0] sig_idx;
      logic       lat_data;
      logic       lat_cmd;
      logic       lat_lo;
      logic       lat_hi;
      logic       commit;
      act_type    act;
   } cmd_type;

   typedef struct packed {
      logic [1:0] kind;
      logic       loaded;
      logic       at_end;
      logic       len_ok;
      logic       sig_match;
      logic       is_timer;
      logic       out_free;
   } status_type;

endpackage

@@ rtl/ocep_dpath.sv @@
// Datapath of the capture event parser: file byte store, playback state,
// byte latches, event decode and the result register. Uses ocep_pkg.
module ocep_dpath #(
   parameter int BUF_DEPTH  = 65536,
   parameter int MIN_LENGTH = 12
) (
   input  logic                clock,
   input  logic                reset,
   input  logic [1:0]          req_kind,
   input  logic [15:0]         req_address,
   input  logic [7:0]          req_byte_value,
   input  logic [16:0]         req_length,
   input  logic                csr_valid,
   input  logic [7:0]          csr_loop_count,
   input  ocep_pkg::cmd_type   cmd,
   output ocep_pkg::status_type status,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [9:0]          rsp_events,
   output logic [23:0]         rsp_delay_ticks,
   output logic [16:0]         rsp_timer_period,
   output logic                rsp_chip_select,
   output logic [7:0]          rsp_reg_index,
   output logic [7:0]          rsp_reg_data,
   output logic                rsp_load_ok
);
   import ocep_pkg::*;

   localparam int LEN_W = $clog2(BUF_DEPTH + 1);
   localparam int POS_W = LEN_W + 1;
   localparam int IDX_W = $clog2(BUF_DEPTH);

   // captured item
   logic [1:0]       kind_ff;
   logic [15:0]      addr_ff;
   logic [7:0]       byte_ff;
   logic [LEN_W-1:0] len_ff;
   logic [LEN_W-1:0] len_clip;
   logic [LEN_W-1:0] len_even;

   // playback state
   logic [POS_W-1:0] pos_ff, pos_in;
   logic [LEN_W-1:0] end_ff, end_in;
   logic [16:0]      period_ff, period_in;
   logic [7:0]       loops_ff, loops_in;
   logic             base_ff, base_in;
   logic             loaded_ff, loaded_in;
   logic [7:0]       loop_count_ff;

   // byte fetch
   logic [7:0]       mem [BUF_DEPTH];
   logic [7:0]       mem_q_ff;
   logic             hit_ff;
   logic [POS_W-1:0] raddr;
   logic [IDX_W-1:0] port_idx;
   logic             wr_en;
   logic             addr_in_range;
   logic [7:0]       rd_byte;
   logic [7:0]       data_ff, cmd_ff, lo_ff, hi_ff;
   logic [16:0]      hdr_period;
   logic [24:0]      prod;

   // result
   logic             rsp_valid_ff;
   logic [9:0]       ev_ff, ev_in;
   logic [23:0]      ticks_ff, ticks_in;
   logic [16:0]      per_out_ff;
   logic             base_out_ff;
   logic [7:0]       ridx_ff, ridx_in;
   logic [7:0]       rdat_ff, rdat_in;
   logic             ok_ff, ok_in;

   // clip to the store size, then round down to even
   always_comb begin
      if (32'(req_length) > 32'(BUF_DEPTH)) begin
         len_clip = LEN_W'(BUF_DEPTH);
      end else begin
         len_clip = LEN_W'(req_length);
      end
      len_even = {len_clip[LEN_W-1:1], 1'b0};
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         kind_ff <= req_kind;
         addr_ff <= req_address;
         byte_ff <= req_byte_value;
         len_ff  <= len_even;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         loop_count_ff <= 8'd1;
      end else if (csr_valid) begin
         loop_count_ff <= csr_loop_count;
      end
   end

   always_comb begin
      case (cmd.rsel)
         RS_SIG:  raddr = POS_W'(cmd.sig_idx);
         RS_HDR0: raddr = POS_W'(PERIOD_OFFSET);
         RS_HDR1: raddr = POS_W'(PERIOD_OFFSET + 1);
         RS_POS0: raddr = pos_ff;
         RS_POS1: raddr = pos_ff + POS_W'(1);
         RS_POS2: raddr = pos_ff + POS_W'(2);
         RS_POS3: raddr = pos_ff + POS_W'(3);
         default: raddr = pos_ff;
      endcase
   end

   assign addr_in_range = 32'(addr_ff) < 32'(BUF_DEPTH);
   assign wr_en         = cmd.commit && (cmd.act == ACT_LOAD) && addr_in_range;
   assign port_idx      = wr_en ? IDX_W'(addr_ff) : raddr[IDX_W-1:0];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[port_idx] <= byte_ff;
      end
      mem_q_ff <= mem[port_idx];
      hit_ff   <= raddr < {1'b0, end_ff};
   end

   // bytes at or past the data end read as zero
   assign rd_byte = hit_ff ? mem_q_ff : 8'd0;

   always_ff @(posedge clock) begin
      if (cmd.lat_data) data_ff <= rd_byte;
      if (cmd.lat_cmd)  cmd_ff  <= rd_byte;
      if (cmd.lat_lo)   lo_ff   <= rd_byte;
      if (cmd.lat_hi)   hi_ff   <= rd_byte;
   end

   assign hdr_period = ({hi_ff, lo_ff} == 16'd0) ? FULL_PERIOD : {1'b0, hi_ff, lo_ff};
   assign prod       = 25'(period_ff) * 25'(data_ff);

   always_comb begin
      pos_in    = pos_ff;
      end_in    = end_ff;
      period_in = period_ff;
      loops_in  = loops_ff;
      base_in   = base_ff;
      loaded_in = loaded_ff;
      ev_in     = 10'd0;
      ticks_in  = 24'd0;
      ridx_in   = 8'd0;
      rdat_in   = 8'd0;
      ok_in     = 1'b0;
      if (cmd.set_end) begin
         end_in = len_ff;
      end
      if (cmd.commit) begin
         case (cmd.act)
            ACT_START_OK: begin
               period_in = hdr_period;
               pos_in    = POS_W'(DATA_START);
               loops_in  = loop_count_ff;
               loaded_in = 1'b1;
               ok_in     = 1'b1;
            end
            ACT_START_BAD: begin
               end_in    = '0;
               pos_in    = '0;
               loaded_in = 1'b0;
            end
            ACT_REWIND: begin
               pos_in    = POS_W'(DATA_START);
               period_in = hdr_period;
               base_in   = 1'b0;
               ev_in     = EV_TIMER | EV_BASE0 | EV_BCHG;
               if (loops_ff == 8'd0) begin
                  ev_in = ev_in | EV_RESTART;
               end else begin
                  loops_in = loops_ff - 8'd1;
                  ev_in    = ev_in | ((loops_ff == 8'd1) ? EV_STOP : EV_RESTART);
               end
            end
            ACT_TIMER: begin
               period_in = hdr_period;
               pos_in    = pos_ff + POS_W'(4);
               ev_in     = EV_TIMER;
            end
            ACT_EVENT: begin
               pos_in = pos_ff + POS_W'(2);
               if (cmd_ff == CMD_DELAY) begin
                  ev_in    = EV_DELAY;
                  ticks_in = prod[23:0];
               end else if (cmd_ff == CMD_CTRL) begin
                  if (data_ff == CTRL_BASE0) begin
                     base_in = 1'b0;
                     ev_in   = EV_BASE0 | EV_BCHG;
                  end else if (data_ff == CTRL_BASE1) begin
                     base_in = 1'b1;
                     ev_in   = EV_BASE1 | EV_BCHG;
                  end else begin
                     ev_in = EV_UNKNOWN;
                  end
               end else if (cmd_ff == MARK_BYTE && data_ff == MARK_BYTE) begin
                  pos_in = {1'b0, end_ff};
                  ev_in  = EV_ENDMARK;
               end else begin
                  ridx_in = cmd_ff;
                  rdat_in = data_ff;
                  ev_in   = EV_WRITE;
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff    <= '0;
         end_ff    <= '0;
         period_ff <= FULL_PERIOD;
         loops_ff  <= 8'd1;
         base_ff   <= 1'b0;
         loaded_ff <= 1'b0;
      end else begin
         pos_ff    <= pos_in;
         end_ff    <= end_in;
         period_ff <= period_in;
         loops_ff  <= loops_in;
         base_ff   <= base_in;
         loaded_ff <= loaded_in;
      end
   end

   // result register: hold until the transfer completes
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.commit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         ev_ff       <= ev_in;
         ticks_ff    <= ticks_in;
         per_out_ff  <= period_in;
         base_out_ff <= base_in;
         ridx_ff     <= ridx_in;
         rdat_ff     <= rdat_in;
         ok_ff       <= ok_in;
      end
   end

   assign status.kind      = kind_ff;
   assign status.loaded    = loaded_ff;
   assign status.at_end    = pos_ff >= {1'b0, end_ff};
   assign status.len_ok    = len_ff >= LEN_W'(MIN_LENGTH);
   assign status.sig_match = rd_byte == sig_byte(cmd.sig_idx);
   assign status.is_timer  = (cmd_ff == CMD_CTRL) && (data_ff == CTRL_TIMER);
   assign status.out_free  = !rsp_valid_ff || rsp_ready;

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_events       = ev_ff;
   assign rsp_delay_ticks  = ticks_ff;
   assign rsp_timer_period = per_out_ff;
   assign rsp_chip_select  = base_out_ff;
   assign rsp_reg_index    = ridx_ff;
   assign rsp_reg_data     = rdat_ff;
   assign rsp_load_ok      = ok_ff;

endmodule

@@ rtl/ocep_ctrl.sv @@
// Sequencer of the capture event parser: steps byte reads through the store
// and tells the datapath when to latch and commit. Uses ocep_pkg.
module ocep_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  ocep_pkg::status_type status,
   output ocep_pkg::cmd_type    cmd
);
   import ocep_pkg::*;

   state_type  state_ff, state_in;
   act_type    act_ff, act_in;
   logic [2:0] cnt_ff, cnt_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         act_ff   <= ACT_NONE;
         cnt_ff   <= 3'd0;
      end else begin
         state_ff <= state_in;
         act_ff   <= act_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_comb begin
      state_in    = state_ff;
      act_in      = act_ff;
      cnt_in      = cnt_ff;
      cmd         = '0;
      cmd.rsel    = RS_POS0;
      cmd.act     = act_ff;
      cmd.sig_idx = cnt_ff;
      req_ready   = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_DISPATCH;
            end
         end
         ST_DISPATCH: begin
            case (status.kind)
               KIND_LOAD: begin
                  act_in   = ACT_LOAD;
                  state_in = ST_COMMIT;
               end
               KIND_START: begin
                  if (status.len_ok) begin
                     cmd.set_end = 1'b1;
                     cnt_in      = 3'd0;
                     state_in    = ST_SIG_ADDR;
                  end else begin
                     act_in   = ACT_START_BAD;
                     state_in = ST_COMMIT;
                  end
               end
               KIND_NEXT: begin
                  if (!status.loaded) begin
                     act_in   = ACT_NONE;
                     state_in = ST_COMMIT;
                  end else if (status.at_end) begin
                     act_in   = ACT_REWIND;
                     state_in = ST_HDR_LO;
                  end else begin
                     state_in = ST_EV_RD0;
                  end
               end
               default: begin
                  act_in   = ACT_NONE;
                  state_in = ST_COMMIT;
               end
            endcase
         end
         ST_SIG_ADDR: begin
            cmd.rsel = RS_SIG;
            state_in = ST_SIG_CHK;
         end
         ST_SIG_CHK: begin
            if (!status.sig_match) begin
               act_in   = ACT_START_BAD;
               state_in = ST_COMMIT;
            end else if (cnt_ff == 3'(SIG_LEN - 1)) begin
               act_in   = ACT_START_OK;
               state_in = ST_HDR_LO;
            end else begin
               cnt_in   = cnt_ff + 3'd1;
               state_in = ST_SIG_ADDR;
            end
         end
         ST_HDR_LO: begin
            cmd.rsel = RS_HDR0;
            state_in = ST_HDR_HI;
         end
         ST_HDR_HI: begin
            cmd.lat_lo = 1'b1;
            cmd.rsel   = RS_HDR1;
            state_in   = ST_HDR_WT;
         end
         ST_HDR_WT: begin
            cmd.lat_hi = 1'b1;
            state_in   = ST_COMMIT;
         end
         ST_EV_RD0: begin
            cmd.rsel = RS_POS0;
            state_in = ST_EV_RD1;
         end
         ST_EV_RD1: begin
            cmd.lat_data = 1'b1;
            cmd.rsel     = RS_POS1;
            state_in     = ST_EV_WT;
         end
         ST_EV_WT: begin
            cmd.lat_cmd = 1'b1;
            state_in    = ST_EV_DEC;
         end
         ST_EV_DEC: begin
            if (status.is_timer) begin
               cmd.rsel = RS_POS2;
               act_in   = ACT_TIMER;
               state_in = ST_TM_HI;
            end else begin
               act_in   = ACT_EVENT;
               state_in = ST_COMMIT;
            end
         end
         ST_TM_HI: begin
            cmd.lat_lo = 1'b1;
            cmd.rsel   = RS_POS3;
            state_in   = ST_HDR_WT;
         end
         ST_COMMIT: begin
            // hold until the result register is free
            if (status.out_free) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

@@ rtl/opl_capture_event_parser.sv @@
// Top level of the capture event parser: sequencer plus datapath.
// Depends on ocep_pkg, ocep_ctrl and ocep_dpath.
//
// Usage: the req channel carries load, start and next-event items; every
// accepted item returns exactly one result on the rsp channel. The csr
// channel writes loop_count and is always ready; write it only while idle.
// Items are handled one at a time. A start checks each signature byte
// and then reads the header word; an end-of-data rewind rereads the
// header word; a next event reads its two bytes and, for a timer set,
// the period word after them. The single-port byte store gives one
// byte per cycle through a registered read port. req_ready returns in
// the cycle after the result is committed.
// A waiting result does not block the next item: it is processed and
// holds in its commit step until the receiver takes the earlier one.
// Reset (synchronous): nothing loaded, period 65536, chip base 0, loop
// count 1. Store contents are undefined until loaded.
module opl_capture_event_parser #(
   parameter int BUF_DEPTH  = 65536,
   parameter int MIN_LENGTH = 12
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_kind,
   input  logic [15:0] req_address,
   input  logic [7:0]  req_byte_value,
   input  logic [16:0] req_length,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [9:0]  rsp_events,
   output logic [23:0] rsp_delay_ticks,
   output logic [16:0] rsp_timer_period,
   output logic        rsp_chip_select,
   output logic [7:0]  rsp_reg_index,
   output logic [7:0]  rsp_reg_data,
   output logic        rsp_load_ok,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_loop_count
);
   import ocep_pkg::*;

   cmd_type    cmd;
   status_type status;

   assign csr_ready = 1'b1;

   ocep_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   ocep_dpath #(
      .BUF_DEPTH  (BUF_DEPTH),
      .MIN_LENGTH (MIN_LENGTH)
   ) u_dpath (
      .clock            (clock),
      .reset            (reset),
      .req_kind         (req_kind),
      .req_address      (req_address),
      .req_byte_value   (req_byte_value),
      .req_length       (req_length),
      .csr_valid        (csr_valid),
      .csr_loop_count   (csr_loop_count),
      .cmd              (cmd),
      .status           (status),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_events       (rsp_events),
      .rsp_delay_ticks  (rsp_delay_ticks),
      .rsp_timer_period (rsp_timer_period),
      .rsp_chip_select  (rsp_chip_select),
      .rsp_reg_index    (rsp_reg_index),
      .rsp_reg_data     (rsp_reg_data),
      .rsp_load_ok      (rsp_load_ok)
   );

endmodule
